// File: rtl/hrf_pkg.sv
// shared types, codes and limits of the http response header framer
package hrf_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int CODE_W   = 10;
  localparam int LINE_W   = 12;
  localparam int TOTAL_W  = 16;
  localparam int SUM_W    = TOTAL_W + 1;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = TOTAL_W;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 1'd1;
  localparam logic [LINE_W-1:0]  MAX_LINE_RST  = 12'd1024;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL_RST = 16'd8192;

  // queue between classifier and header engine
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // result kinds
  localparam logic [KIND_W-1:0] K_HEADER = 3'd0;
  localparam logic [KIND_W-1:0] K_ACCEPT = 3'd1;
  localparam logic [KIND_W-1:0] K_BODY   = 3'd2;
  localparam logic [KIND_W-1:0] K_REJECT = 3'd3;
  localparam logic [KIND_W-1:0] K_LARGE  = 3'd4;
  localparam logic [KIND_W-1:0] K_DROP   = 3'd5;

  // response phases
  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_HEAD   = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // byte values
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // status codes that count as success
  localparam logic [CODE_W-1:0] CODE_OK_LO = 10'd200;
  localparam logic [CODE_W-1:0] CODE_OK_HI = 10'd299;

  // classified item as it travels through the queue
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              chunk_end;
    logic              start_new;
    logic              is_lf;
    logic              is_cr;
    logic              is_ws;
    logic              is_sp;
  } item_t;

  // configuration registers as seen by the header engine
  typedef struct packed {
    logic [LINE_W-1:0]  max_line_length;
    logic [TOTAL_W-1:0] max_header_total;
  } cfg_t;

endpackage

// File: rtl/hrf_ifs.sv
// valid/ready channel interfaces of the framer
interface hrf_in_if;
  logic                         valid;
  logic                         ready;
  logic [hrf_pkg::BYTE_W-1:0]   rx_byte;
  logic                         chunk_end;
  logic                         start_new;

  modport source (output valid, rx_byte, chunk_end, start_new, input ready);
  modport sink   (input valid, rx_byte, chunk_end, start_new, output ready);
endinterface

interface hrf_out_if;
  logic                         valid;
  logic                         ready;
  logic [hrf_pkg::KIND_W-1:0]   kind;
  logic [hrf_pkg::BYTE_W-1:0]   body_byte;
  logic [hrf_pkg::CODE_W-1:0]   status_code;
  logic                         chunk_last;

  modport source (output valid, kind, body_byte, status_code, chunk_last, input ready);
  modport sink   (input valid, kind, body_byte, status_code, chunk_last, output ready);
endinterface

// File: rtl/http_response_header_framer_core.sv
// top level of the http response header framer
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        rx_byte, chunk_end, start_new
//   out_ch   out  valid/ready        kind, body_byte, status_code, chunk_last
//   cfg_*    in   cfg_we only        cfg_index, cfg_data
//
// one item per cycle sustained while out_ch is ready; one result per item, via the queue and the result register
// the header engine computes all next parser state combinationally for each item
// a two-entry queue lets input be taken while a result waits on out_ch
// when out_ch stalls the queue fills and in_ch.ready drops
// synchronous active-low reset; limits return to 1024 and 8192 bytes
module http_response_header_framer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  hrf_in_if.sink                          in_ch,
  hrf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hrf_pkg::CFG_DAT_W-1:0]   cfg_data
);

  hrf_pkg::cfg_t  cfg_r;
  hrf_pkg::item_t push_item;
  hrf_pkg::item_t head_item;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_not_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_line_length  <= hrf_pkg::MAX_LINE_RST;
      cfg_r.max_header_total <= hrf_pkg::MAX_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrf_pkg::REG_MAX_LINE:  cfg_r.max_line_length  <= cfg_data[hrf_pkg::LINE_W-1:0];
        hrf_pkg::REG_MAX_TOTAL: cfg_r.max_header_total <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier
  hrf_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  // item queue
  hrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // header engine
  hrf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// File: rtl/hrf_front.sv
// front end: takes input items and classifies each byte
module hrf_front (
  hrf_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output hrf_pkg::item_t q_item
);

  // handshake follows queue space
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // byte classes used by the line parser
  always_comb begin
    q_item.rx_byte   = in_ch.rx_byte;
    q_item.chunk_end = in_ch.chunk_end;
    q_item.start_new = in_ch.start_new;
    q_item.is_lf     = (in_ch.rx_byte == hrf_pkg::CH_LF);
    q_item.is_cr     = (in_ch.rx_byte == hrf_pkg::CH_CR);
    q_item.is_sp     = (in_ch.rx_byte == hrf_pkg::CH_SPACE);
    q_item.is_ws     = (in_ch.rx_byte == hrf_pkg::CH_SPACE) ||
                       (in_ch.rx_byte == hrf_pkg::CH_TAB) ||
                       (in_ch.rx_byte == hrf_pkg::CH_VT) ||
                       (in_ch.rx_byte == hrf_pkg::CH_FF);
  end

endmodule

// File: rtl/hrf_queue.sv
// short item queue between the classifier and the header engine
module hrf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrf_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output hrf_pkg::item_t head_item
);

  hrf_pkg::item_t             slot_r [hrf_pkg::Q_DEPTH];
  logic [hrf_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hrf_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hrf_pkg::Q_CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == hrf_pkg::Q_CW'(hrf_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hrf_pkg::Q_AW'(hrf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == hrf_pkg::Q_AW'(hrf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/hrf_back.sv
// header engine: line trimming, status code capture and result register
module hrf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hrf_pkg::cfg_t  cfg,
  input  logic           q_not_empty,
  input  hrf_pkg::item_t q_item,
  output logic           q_pop,
  hrf_out_if.source      out_ch
);

  // parser state
  logic [1:0]                  phase_r, phase_nxt;
  logic [hrf_pkg::LINE_W-1:0]  line_count_r, line_count_nxt;
  logic [hrf_pkg::LINE_W-1:0]  first_pos_r, first_pos_nxt;
  logic [hrf_pkg::LINE_W-1:0]  last_pos_r, last_pos_nxt;
  logic                        text_seen_r, text_seen_nxt;
  logic [hrf_pkg::SUM_W-1:0]   total_r, total_nxt;
  logic                        lines_stored_r, lines_stored_nxt;
  logic                        space_seen_r, space_seen_nxt;
  logic [hrf_pkg::LINE_W-1:0]  space_pos_r, space_pos_nxt;
  logic [hrf_pkg::BYTE_W-1:0]  code_c0_r, code_c0_nxt;
  logic [hrf_pkg::BYTE_W-1:0]  code_c1_r, code_c1_nxt;
  logic [hrf_pkg::BYTE_W-1:0]  code_c2_r, code_c2_nxt;
  logic [1:0]                  code_cnt_r, code_cnt_nxt;
  logic [hrf_pkg::CODE_W-1:0]  status_r, status_nxt;

  // result register
  logic                        out_valid_r;
  logic [hrf_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [hrf_pkg::BYTE_W-1:0]  body_r, body_nxt;
  logic                        last_r;

  // working values
  logic [hrf_pkg::LINE_W:0]    line_len;
  logic [hrf_pkg::SUM_W-1:0]   sum;
  logic [hrf_pkg::LINE_W-1:0]  room;
  logic [3:0]                  d0, d1, d2;
  logic                        dig0, dig1, dig2;
  logic                        code_ok;
  logic [hrf_pkg::CODE_W-1:0]  code_val;

  assign q_pop = q_not_empty && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.body_byte   = body_r;
  assign out_ch.status_code = status_r;
  assign out_ch.chunk_last  = last_r;

  // next state for one item
  always_comb begin
    phase_nxt        = phase_r;
    line_count_nxt   = line_count_r;
    first_pos_nxt    = first_pos_r;
    last_pos_nxt     = last_pos_r;
    text_seen_nxt    = text_seen_r;
    total_nxt        = total_r;
    lines_stored_nxt = lines_stored_r;
    space_seen_nxt   = space_seen_r;
    space_pos_nxt    = space_pos_r;
    code_c0_nxt      = code_c0_r;
    code_c1_nxt      = code_c1_r;
    code_c2_nxt      = code_c2_r;
    code_cnt_nxt     = code_cnt_r;
    status_nxt       = status_r;
    kind_nxt         = hrf_pkg::K_HEADER;
    body_nxt         = '0;
    line_len         = '0;
    sum              = '0;
    room             = '0;
    d0               = '0;
    d1               = '0;
    d2               = '0;
    dig0             = 1'b0;
    dig1             = 1'b0;
    dig2             = 1'b0;
    code_ok          = 1'b0;
    code_val         = '0;

    // new response clears everything first
    if (q_item.start_new) begin
      phase_nxt        = hrf_pkg::PH_EXPECT;
      line_count_nxt   = '0;
      first_pos_nxt    = '0;
      last_pos_nxt     = '0;
      text_seen_nxt    = 1'b0;
      total_nxt        = '0;
      lines_stored_nxt = 1'b0;
      space_seen_nxt   = 1'b0;
      space_pos_nxt    = '0;
      code_c0_nxt      = '0;
      code_c1_nxt      = '0;
      code_c2_nxt      = '0;
      code_cnt_nxt     = '0;
      status_nxt       = '0;
    end

    unique case (phase_nxt)
      hrf_pkg::PH_BODY: begin
        kind_nxt = hrf_pkg::K_BODY;
        body_nxt = q_item.rx_byte;
      end
      hrf_pkg::PH_STOP: begin
        kind_nxt = hrf_pkg::K_DROP;
      end
      default: begin
        phase_nxt = hrf_pkg::PH_HEAD;
        if (q_item.is_lf) begin
          // end of line: trimmed length
          line_len = text_seen_nxt ?
                     ({1'b0, last_pos_nxt} - {1'b0, first_pos_nxt} + 1'b1) : '0;
          if (line_len == '0) begin
            // blank line closes the headers; check the code digits
            d0   = 4'(code_c0_nxt - hrf_pkg::CH_ZERO);
            d1   = 4'(code_c1_nxt - hrf_pkg::CH_ZERO);
            d2   = 4'(code_c2_nxt - hrf_pkg::CH_ZERO);
            dig0 = (code_c0_nxt >= hrf_pkg::CH_ZERO) && (code_c0_nxt <= hrf_pkg::CH_NINE);
            dig1 = (code_c1_nxt >= hrf_pkg::CH_ZERO) && (code_c1_nxt <= hrf_pkg::CH_NINE);
            dig2 = (code_c2_nxt >= hrf_pkg::CH_ZERO) && (code_c2_nxt <= hrf_pkg::CH_NINE);
            case (code_cnt_nxt)
              2'd1: begin
                code_ok  = dig0;
                code_val = hrf_pkg::CODE_W'(d0);
              end
              2'd2: begin
                code_ok  = dig0 && dig1;
                code_val = hrf_pkg::CODE_W'(d0) * 10'd10 + hrf_pkg::CODE_W'(d1);
              end
              2'd3: begin
                code_ok  = dig0 && dig1 && dig2;
                code_val = hrf_pkg::CODE_W'(d0) * 10'd100 +
                           hrf_pkg::CODE_W'(d1) * 10'd10 + hrf_pkg::CODE_W'(d2);
              end
              default: begin
                code_ok  = 1'b0;
                code_val = '0;
              end
            endcase
            line_count_nxt = '0;
            first_pos_nxt  = '0;
            last_pos_nxt   = '0;
            text_seen_nxt  = 1'b0;
            if (lines_stored_nxt && space_seen_nxt && code_ok) begin
              status_nxt = code_val;
              if (code_val >= hrf_pkg::CODE_OK_LO && code_val <= hrf_pkg::CODE_OK_HI) begin
                kind_nxt  = hrf_pkg::K_ACCEPT;
                phase_nxt = hrf_pkg::PH_BODY;
              end else begin
                kind_nxt  = hrf_pkg::K_REJECT;
                phase_nxt = hrf_pkg::PH_STOP;
              end
            end else begin
              kind_nxt  = hrf_pkg::K_REJECT;
              phase_nxt = hrf_pkg::PH_STOP;
            end
          end else begin
            // add line into the running total
            sum       = total_nxt + hrf_pkg::SUM_W'(line_len);
            total_nxt = sum;
            if (sum > {1'b0, cfg.max_header_total}) begin
              status_nxt = '0;
              phase_nxt  = hrf_pkg::PH_STOP;
              kind_nxt   = hrf_pkg::K_LARGE;
            end else if (!lines_stored_nxt) begin
              // status line done: cut the code at the trimmed end
              if (space_seen_nxt && (space_pos_nxt < last_pos_nxt)) begin
                room = last_pos_nxt - space_pos_nxt;
                if (hrf_pkg::LINE_W'(code_cnt_nxt) > room) begin
                  code_cnt_nxt = room[1:0];
                end
              end else begin
                space_seen_nxt = 1'b0;
                code_cnt_nxt   = '0;
              end
              lines_stored_nxt = 1'b1;
            end
            line_count_nxt = '0;
            first_pos_nxt  = '0;
            last_pos_nxt   = '0;
            text_seen_nxt  = 1'b0;
          end
        end else if (!q_item.is_cr && (line_count_nxt < cfg.max_line_length)) begin
          // keep the byte
          line_count_nxt = line_count_nxt + 1'b1;
          if (!lines_stored_nxt) begin
            if (space_seen_nxt) begin
              case (code_cnt_nxt)
                2'd0:    code_c0_nxt = q_item.rx_byte;
                2'd1:    code_c1_nxt = q_item.rx_byte;
                2'd2:    code_c2_nxt = q_item.rx_byte;
                default: code_c0_nxt = code_c0_nxt;
              endcase
              if (code_cnt_nxt != 2'd3) begin
                code_cnt_nxt = code_cnt_nxt + 1'b1;
              end
            end else if (text_seen_nxt && q_item.is_sp) begin
              space_seen_nxt = 1'b1;
              space_pos_nxt  = line_count_r;
            end
          end
          if (!q_item.is_ws) begin
            if (!text_seen_nxt) begin
              text_seen_nxt = 1'b1;
              first_pos_nxt = line_count_nxt - 1'b1;
            end
            last_pos_nxt = line_count_nxt - 1'b1;
          end
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= hrf_pkg::PH_EXPECT;
      line_count_r   <= '0;
      first_pos_r    <= '0;
      last_pos_r     <= '0;
      text_seen_r    <= 1'b0;
      total_r        <= '0;
      lines_stored_r <= 1'b0;
      space_seen_r   <= 1'b0;
      space_pos_r    <= '0;
      code_c0_r      <= '0;
      code_c1_r      <= '0;
      code_c2_r      <= '0;
      code_cnt_r     <= '0;
      status_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r        <= phase_nxt;
        line_count_r   <= line_count_nxt;
        first_pos_r    <= first_pos_nxt;
        last_pos_r     <= last_pos_nxt;
        text_seen_r    <= text_seen_nxt;
        total_r        <= total_nxt;
        lines_stored_r <= lines_stored_nxt;
        space_seen_r   <= space_seen_nxt;
        space_pos_r    <= space_pos_nxt;
        code_c0_r      <= code_c0_nxt;
        code_c1_r      <= code_c1_nxt;
        code_c2_r      <= code_c2_nxt;
        code_cnt_r     <= code_cnt_nxt;
        status_r       <= status_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= kind_nxt;
      body_r <= body_nxt;
      last_r <= q_item.chunk_end;
    end
  end

endmodule
